FILE: sv/gdn_pkg.sv
package gdn_pkg;

    // Running day count: wide enough for every year the 14-bit input can name
    // plus the largest day offset of a 16-bit day field.
    localparam int TOTAL_W = 23;
    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 16;
    localparam int NDAY_W  = 5;
    localparam int QUOT_W  = 8;
    localparam int RDIV_W  = 12;

    // floor(x / 25) == (x * RECIP25) >> RECIP25_SHIFT for every x below 4096.
    localparam logic [12:0] RECIP25       = 13'd5243;
    localparam int          RECIP25_SHIFT = 17;

    localparam logic [TOTAL_W-1:0] DAYS_400Y    = TOTAL_W'(146097);
    localparam logic [TOTAL_W-1:0] DAYS_100Y    = TOTAL_W'(36524);
    localparam logic [TOTAL_W-1:0] DAYS_4Y      = TOTAL_W'(1461);
    localparam logic [TOTAL_W-1:0] DAYS_YEAR    = TOTAL_W'(365);
    localparam logic [MONTH_W-1:0] MONTH_JAN    = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB    = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC    = 4'd12;

    typedef struct packed {
        logic [YEAR_W-1:0]  in_year;
        logic [MONTH_W-1:0] in_month;
        logic [DAY_W-1:0]   in_day;
    } in_word_t;

    typedef struct packed {
        logic [YEAR_W-1:0]  norm_year;
        logic [MONTH_W-1:0] norm_month;
        logic [NDAY_W-1:0]  norm_day;
    } out_word_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_DIV100,
        OP_DIV400,
        OP_DIVY,
        OP_SUM1,
        OP_SUM2,
        OP_Y400,
        OP_Y100,
        OP_Y4,
        OP_Y1,
        OP_MON,
        OP_OUT
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV100,
        ST_DIV400,
        ST_DIVY,
        ST_SUM1,
        ST_SUM2,
        ST_Y400,
        ST_Y100,
        ST_Y4,
        ST_Y1,
        ST_MON
    } state_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic take400;
        logic take100;
        logic take4;
        logic take1;
        logic take_mon;
    } status_t;

    // Days of a month in a common year.
    function automatic logic [NDAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
        logic [NDAY_W-1:0] r;
        case (m)
            4'd2:    r = 5'd28;
            4'd4:    r = 5'd30;
            4'd6:    r = 5'd30;
            4'd9:    r = 5'd30;
            4'd11:   r = 5'd30;
            default: r = 5'd31;
        endcase
        return r;
    endfunction

    // Days of a common year that lie before the first of month m.
    function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
        logic [8:0] r;
        case (m)
            4'd2:    r = 9'd31;
            4'd3:    r = 9'd59;
            4'd4:    r = 9'd90;
            4'd5:    r = 9'd120;
            4'd6:    r = 9'd151;
            4'd7:    r = 9'd181;
            4'd8:    r = 9'd212;
            4'd9:    r = 9'd243;
            4'd10:   r = 9'd273;
            4'd11:   r = 9'd304;
            4'd12:   r = 9'd334;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

FILE: sv/gdn_ctrl.sv
module gdn_ctrl
    import gdn_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd.op         = OP_NONE;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_DIV100;
                end
            end
            ST_DIV100:
            begin
                cmd.op     = OP_DIV100;
                state_next = ST_DIV400;
            end
            ST_DIV400:
            begin
                cmd.op     = OP_DIV400;
                state_next = ST_DIVY;
            end
            ST_DIVY:
            begin
                cmd.op     = OP_DIVY;
                state_next = ST_SUM1;
            end
            ST_SUM1:
            begin
                cmd.op     = OP_SUM1;
                state_next = ST_SUM2;
            end
            ST_SUM2:
            begin
                cmd.op     = OP_SUM2;
                state_next = ST_Y400;
            end
            ST_Y400:
            begin
                if (status.take400)
                    cmd.op = OP_Y400;
                else
                    state_next = ST_Y100;
            end
            ST_Y100:
            begin
                if (status.take100)
                    cmd.op = OP_Y100;
                else
                    state_next = ST_Y4;
            end
            ST_Y4:
            begin
                if (status.take4)
                    cmd.op = OP_Y4;
                else
                    state_next = ST_Y1;
            end
            ST_Y1:
            begin
                if (status.take1)
                    cmd.op = OP_Y1;
                else
                    state_next = ST_MON;
            end
            ST_MON:
            begin
                if (status.take_mon)
                    cmd.op = OP_MON;
                else if (!out_valid_reg || out_ready)
                begin
                    cmd.op         = OP_OUT;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

FILE: sv/gdn_datapath.sv
module gdn_datapath
    import gdn_pkg::*;
#(
    parameter int unsigned MAX_YEAR      = 9999,
    parameter int unsigned MAX_INPUT_DAY = 65535
)
(
    input  logic      clk,
    input  in_word_t  in_word,
    input  cmd_t      cmd,
    output status_t   status,
    output out_word_t out_word
);

    logic [YEAR_W-1:0]  y_in_reg;
    logic [MONTH_W-1:0] m_in_reg;
    logic [DAY_W-1:0]   d_in_reg;
    logic [YEAR_W-1:0]  n_reg;
    logic [QUOT_W-1:0]  q100_reg, q400_reg, qy_reg;
    logic               leap_in_reg;
    logic [TOTAL_W-1:0] total_reg;
    logic [YEAR_W-1:0]  yr_reg;
    logic [6:0]         mod100_reg;
    logic [1:0]         cent_reg;
    logic [MONTH_W-1:0] mon_reg;
    out_word_t          out_reg;

    logic [YEAR_W-1:0]  y_clamp;
    logic [MONTH_W-1:0] m_clamp;
    logic [DAY_W-1:0]   d_clamp;

    logic [RDIV_W-1:0]  mul_a;
    logic [24:0]        mul_p;
    logic [QUOT_W-1:0]  quot;

    logic [RDIV_W-1:0]  qy25;
    logic               leap_in;
    logic [TOTAL_W-1:0] sum_in;
    logic               leap_y;
    logic [TOTAL_W-1:0] d100, d4, d1, dmon;

    assign y_clamp = ({2'b00, in_word.in_year} > MAX_YEAR[15:0])
                     ? MAX_YEAR[YEAR_W-1:0] : in_word.in_year;
    assign m_clamp = (in_word.in_month > MONTH_DEC) ? MONTH_DEC : in_word.in_month;
    assign d_clamp = ({4'b0000, in_word.in_day} > MAX_INPUT_DAY[19:0])
                     ? MAX_INPUT_DAY[DAY_W-1:0] : in_word.in_day;

    // One reciprocal multiplier does the three divisions by 25.
    always_comb
    begin
        case (cmd.op)
            OP_DIV100: mul_a = n_reg[YEAR_W-1:2];
            OP_DIV400: mul_a = {2'b00, n_reg[YEAR_W-1:4]};
            default:   mul_a = y_in_reg[YEAR_W-1:2];
        endcase
    end

    assign mul_p = 25'(mul_a) * 25'(RECIP25);
    assign quot  = mul_p[RECIP25_SHIFT +: QUOT_W];

    // Input year is a leap year when it is a multiple of four and either not a
    // century or a century whose count is a multiple of four.
    assign qy25    = RDIV_W'(qy_reg) * RDIV_W'(25);
    assign leap_in = (y_in_reg[1:0] == 2'b00)
                     && ((y_in_reg[YEAR_W-1:2] != qy25) || (qy_reg[1:0] == 2'b00));

    assign sum_in = total_reg
                  + TOTAL_W'(n_reg[YEAR_W-1:2])
                  + TOTAL_W'(q400_reg)
                  + TOTAL_W'(d_in_reg)
                  + TOTAL_W'(days_before(m_in_reg))
                  + TOTAL_W'(leap_in_reg && (m_in_reg > MONTH_FEB))
                  - TOTAL_W'(q100_reg);

    // Year being counted, tracked by its position within the century and
    // the century count modulo four.
    assign leap_y = (yr_reg[1:0] == 2'b00) && ((mod100_reg != 7'd0) || (cent_reg == 2'd0));

    assign d100 = (cent_reg == 2'd3) ? DAYS_100Y + TOTAL_W'(1) : DAYS_100Y;
    assign d4   = ((mod100_reg == 7'd97) && (cent_reg != 2'd3))
                  ? DAYS_4Y - TOTAL_W'(1) : DAYS_4Y;
    assign d1   = DAYS_YEAR + TOTAL_W'(leap_y);
    assign dmon = ((mon_reg == MONTH_FEB) && leap_y)
                  ? TOTAL_W'(29) : TOTAL_W'(month_len(mon_reg));

    assign status.take400  = total_reg > DAYS_400Y;
    assign status.take100  = total_reg > d100;
    assign status.take4    = total_reg > d4;
    assign status.take1    = total_reg > d1;
    assign status.take_mon = (mon_reg < MONTH_DEC) && (total_reg > dmon);

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                y_in_reg <= y_clamp;
                m_in_reg <= m_clamp;
                d_in_reg <= d_clamp;
                n_reg    <= (y_clamp > YEAR_W'(1)) ? y_clamp - YEAR_W'(1) : '0;
            end
            OP_DIV100: q100_reg <= quot;
            OP_DIV400: q400_reg <= quot;
            OP_DIVY:   qy_reg   <= quot;
            OP_SUM1:
            begin
                total_reg   <= TOTAL_W'(n_reg) * DAYS_YEAR;
                leap_in_reg <= leap_in;
            end
            OP_SUM2:
            begin
                total_reg  <= (sum_in == '0) ? TOTAL_W'(1) : sum_in;
                yr_reg     <= YEAR_W'(1);
                mod100_reg <= 7'd1;
                cent_reg   <= 2'd0;
                mon_reg    <= MONTH_JAN;
            end
            OP_Y400:
            begin
                total_reg <= total_reg - DAYS_400Y;
                yr_reg    <= yr_reg + YEAR_W'(400);
            end
            OP_Y100:
            begin
                total_reg <= total_reg - d100;
                yr_reg    <= yr_reg + YEAR_W'(100);
                cent_reg  <= cent_reg + 2'd1;
            end
            OP_Y4:
            begin
                total_reg <= total_reg - d4;
                yr_reg    <= yr_reg + YEAR_W'(4);
                if (mod100_reg >= 7'd96)
                begin
                    mod100_reg <= mod100_reg - 7'd96;
                    cent_reg   <= cent_reg + 2'd1;
                end
                else
                begin
                    mod100_reg <= mod100_reg + 7'd4;
                end
            end
            OP_Y1:
            begin
                total_reg <= total_reg - d1;
                yr_reg    <= yr_reg + YEAR_W'(1);
                if (mod100_reg == 7'd99)
                begin
                    mod100_reg <= 7'd0;
                    cent_reg   <= cent_reg + 2'd1;
                end
                else
                begin
                    mod100_reg <= mod100_reg + 7'd1;
                end
            end
            OP_MON:
            begin
                total_reg <= total_reg - dmon;
                mon_reg   <= mon_reg + MONTH_W'(1);
            end
            OP_OUT:
            begin
                out_reg.norm_year  <= yr_reg;
                out_reg.norm_month <= mon_reg;
                out_reg.norm_day   <= total_reg[NDAY_W-1:0];
            end
            default:
            begin
            end
        endcase
    end

    assign out_word = out_reg;

endmodule

FILE: sv/gregorian_date_normalizer.sv
// Channel | Direction | Handshake               | Word
// --------+-----------+-------------------------+-------------------------------------
// in      | input     | in_valid / in_ready     | in_word  (in_year, in_month, in_day)
// out     | output    | out_valid / out_ready   | out_word (norm_year, norm_month,
//         |           |                         |           norm_day)
//
// The time from acceptance to out_valid is set by the subtract-and-compare loop of
// the datapath, which takes off one 400-, 100-, 4- or 1-year block or one month per
// cycle, and grows while the word before it is still stalled at the output.
// Reset is asynchronous and active low; it idles the controller and drops out_valid.
// A finished word waits in the output register, and a new input word is
// accepted meanwhile; a stall on the output holds the block only once its
// next result is ready to be written.
module gregorian_date_normalizer
    import gdn_pkg::*;
#(
    parameter int unsigned MAX_YEAR      = 9999,
    parameter int unsigned MAX_INPUT_DAY = 65535
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_word_t  in_word,
    output logic      out_valid,
    input  logic      out_ready,
    output out_word_t out_word
);

    // The controller steps through the setup phase (three divisions by 25 on
    // a shared reciprocal multiplier, then the summing states SUM1 and SUM2 that
    // form the day count from year 1), and then through the reduction phases, moving
    // on from each phase once the datapath reports that its block no longer
    // fits in the remaining count.
    cmd_t    cmd;
    status_t status;

    gdn_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // The datapath holds the clamped input, the running day count, the year
    // counter with its leap tracking, and the output register.
    gdn_datapath #(
        .MAX_YEAR      (MAX_YEAR),
        .MAX_INPUT_DAY (MAX_INPUT_DAY)
    ) u_datapath (
        .clk      (clk),
        .in_word  (in_word),
        .cmd      (cmd),
        .status   (status),
        .out_word (out_word)
    );

endmodule

FILE: sv/gdn_checker.sv
module gdn_checker
    import gdn_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input in_word_t  in_word,
    input logic      out_valid,
    input logic      out_ready,
    input out_word_t out_word
);

    // A stalled result holds its word.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_word))
        else $error("output word changed while stalled");

    // One word at a time: the block stops taking input once a word is in.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while a word is being worked on");

    // A result always names a real month and a nonzero day.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_word.norm_month >= MONTH_JAN) && (out_word.norm_month <= MONTH_DEC)
                      && (out_word.norm_day != '0))
        else $error("output date out of range");

    // No result can appear within the setup cycles after acceptance.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid |=> !out_valid)
        else $error("result appeared too soon after acceptance");

    // Reset leaves no result pending.
    assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("output valid during reset");

endmodule

bind gregorian_date_normalizer gdn_checker u_gdn_checker (.*);

FILE: tb/tb_top.sv
module tb_top;
    import gdn_pkg::*;

    localparam int CLK_PERIOD       = 12;
    localparam int MAX_YEAR         = 9999;
    localparam int DAYS_PER_400Y    = 146097;
    localparam int RANDOM_PER_PHASE = 210;
    // This tail is long enough to catch a stray word.
    localparam int TAIL_CYCLES      = 120;
    localparam int DRAIN_LIMIT      = 20000;
    // The receiver stops taking words for a long stretch once this many have arrived.
    localparam int HOLD_AFTER       = 60;
    localparam int HOLD_CYCLES      = 400;
    localparam int TIMEOUT_CYCLES   = 800000;
    localparam int N_CASES          = 24;

    // One row of the directed table. When 'typed' is set, the expected date is the one
    // written in the row. Otherwise it comes from the predictor.
    typedef struct packed {
        in_word_t  stim;
        logic      typed;
        out_word_t result;
    } date_case_t;

    localparam date_case_t DATE_CASES [N_CASES] = '{
        '{'{14'd1,     4'd1,  16'd1},     1'b1, '{14'd1,    4'd1,  5'd1}},
        // Day zero in January of year 1 has no earlier day, so it clamps to the first.
        '{'{14'd1,     4'd1,  16'd0},     1'b1, '{14'd1,    4'd1,  5'd1}},
        '{'{14'd0,     4'd0,  16'd0},     1'b1, '{14'd1,    4'd1,  5'd1}},
        '{'{14'd9999,  4'd12, 16'd31},    1'b1, '{14'd9999, 4'd12, 5'd31}},
        '{'{14'd2000,  4'd2,  16'd29},    1'b1, '{14'd2000, 4'd2,  5'd29}},
        '{'{14'd1900,  4'd2,  16'd29},    1'b1, '{14'd1900, 4'd3,  5'd1}},
        '{'{14'd2001,  4'd1,  16'd0},     1'b1, '{14'd2000, 4'd12, 5'd31}},
        '{'{14'd2024,  4'd3,  16'd0},     1'b1, '{14'd2024, 4'd2,  5'd29}},
        // Year and month both out of range: they saturate to MAX_YEAR and December.
        '{'{14'd16383, 4'd15, 16'd1},     1'b1, '{14'd9999, 4'd12, 5'd1}},
        '{'{14'd5,     4'd13, 16'd1},     1'b1, '{14'd5,    4'd12, 5'd1}},
        '{'{14'd7,     4'd0,  16'd1},     1'b1, '{14'd7,    4'd1,  5'd1}},
        '{'{14'd1,     4'd1,  16'd365},   1'b1, '{14'd1,    4'd12, 5'd31}},
        '{'{14'd1,     4'd1,  16'd366},   1'b1, '{14'd2,    4'd1,  5'd1}},
        '{'{14'd2023,  4'd12, 16'd32},    1'b1, '{14'd2024, 4'd1,  5'd1}},
        '{'{14'd400,   4'd12, 16'd31},    1'b1, '{14'd400,  4'd12, 5'd31}},
        '{'{14'd399,   4'd12, 16'd32},    1'b1, '{14'd400,  4'd1,  5'd1}},
        '{'{14'd1600,  4'd2,  16'd30},    1'b1, '{14'd1600, 4'd3,  5'd1}},
        // Year zero still treats its February as a leap February when it counts months.
        '{'{14'd0,     4'd3,  16'd1},     1'b0, '0},
        '{'{14'd9999,  4'd12, 16'd65535}, 1'b0, '0},
        '{'{14'd1,     4'd1,  16'd65535}, 1'b0, '0},
        '{'{14'd16383, 4'd15, 16'd65535}, 1'b0, '0},
        '{'{14'd8191,  4'd8,  16'd4096},  1'b0, '0},
        '{'{14'd4096,  4'd10, 16'd43690}, 1'b0, '0},
        '{'{14'd2730,  4'd5,  16'd21845}, 1'b0, '0}
    };

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b1;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    in_word_t  in_word   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_word_t out_word;

    // Dates the block still owes us, oldest first.
    out_word_t expected_dates [$];
    int        failures     = 0;
    int        tx_idle_pct  = 0;
    int        rx_idle_pct  = 0;
    int        dates_taken  = 0;
    int        hold_left    = 0;

    gregorian_date_normalizer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

    always
    begin
        #(CLK_PERIOD / 2) clk = 1'b1;
        #(CLK_PERIOD / 2) clk = 1'b0;
    end

    // Apply the proleptic Gregorian leap rule: every fourth year, except centuries
    // that are not divisible by 400.
    function automatic bit is_leap(input int unsigned y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int unsigned days_in_month(input int unsigned m, input int unsigned y);
        int unsigned len;
        case (m)
            4, 6, 9, 11: len = 30;
            2:           len = is_leap(y) ? 29 : 28;
            default:     len = 31;
        endcase
        return len;
    endfunction

    // The predictor. It turns the date into a count of days from the first of January
    // of year 1, then it takes that count apart again into years and months.
    function automatic out_word_t normalise_date(input in_word_t date);
        int unsigned y;
        int unsigned m;
        int unsigned n;
        int unsigned total;
        int unsigned ylen;
        out_word_t   norm;
        y = date.in_year;
        m = date.in_month;
        if (y > MAX_YEAR)
            y = MAX_YEAR;
        if (m > MONTH_DEC)
            m = MONTH_DEC;
        total = 0;
        if (y > 1)
        begin
            n = y - 1;
            total = n * 365 + n / 4 - n / 100 + n / 400;
        end
        // The months before the given one are counted with the leap rule of the given
        // year, which is year zero itself when the year is zero.
        for (int unsigned i = 1; i < m; i++)
            total += days_in_month(i, y);
        total += date.in_day;
        if (total == 0)
            total = 1;

        y = 1;
        while (total > DAYS_PER_400Y)
        begin
            total -= DAYS_PER_400Y;
            y += 400;
        end
        forever
        begin
            ylen = is_leap(y) ? 366 : 365;
            if (total <= ylen)
                break;
            total -= ylen;
            y++;
        end
        m = 1;
        while (m < 12 && total > days_in_month(m, y))
        begin
            total -= days_in_month(m, y);
            m++;
        end
        norm.norm_year  = y[YEAR_W-1:0];
        norm.norm_month = m[MONTH_W-1:0];
        norm.norm_day   = total[NDAY_W-1:0];
        return norm;
    endfunction

    // Most random words are ordinary dates, some of them running well past their month.
    // The rest are dates near leap boundaries, very long day counts, and raw noise over
    // every bit of every field.
    function automatic in_word_t random_date();
        in_word_t date;
        int       pick;
        pick = $urandom_range(99);
        date.in_year  = YEAR_W'($urandom_range(1, MAX_YEAR));
        date.in_month = MONTH_W'($urandom_range(1, 12));
        if (pick < 45)
            date.in_day = DAY_W'($urandom_range(1, 31));
        else if (pick < 65)
            date.in_day = DAY_W'($urandom_range(0, 800));
        else if (pick < 75)
            date.in_day = DAY_W'($urandom);
        else if (pick < 88)
        begin
            case ($urandom_range(3))
                0:       date.in_year = YEAR_W'($urandom_range(1, 99) * 100);
                1:       date.in_year = YEAR_W'($urandom_range(1, 24) * 400);
                2:       date.in_year = YEAR_W'($urandom_range(1, 3));
                default: date.in_year = YEAR_W'($urandom_range(MAX_YEAR - 3, MAX_YEAR));
            endcase
            date.in_month = $urandom_range(1) ? MONTH_FEB : MONTH_DEC;
            date.in_day   = DAY_W'($urandom_range(0, 62));
        end
        else
        begin
            date.in_year  = YEAR_W'($urandom);
            date.in_month = MONTH_W'($urandom);
            date.in_day   = DAY_W'($urandom);
        end
        return date;
    endfunction

    // Offer one word, after a random gap, and keep it steady until it is accepted.
    // Its expected date is queued at the edge of acceptance.
    task automatic deliver_date(input in_word_t date, input out_word_t result);
        int gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= date;
        do
            @(posedge clk);
        while (!in_ready);
        expected_dates.push_back(result);
    endtask

    // Stop offering words and wait until every date owed so far has come back.
    task automatic await_all_dates();
        int waited;
        in_valid <= 1'b0;
        waited = 0;
        while (expected_dates.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
    endtask

    task automatic deliver_random_dates();
        in_word_t date;
        for (int k = 0; k < RANDOM_PER_PHASE; k++)
        begin
            date = random_date();
            deliver_date(date, normalise_date(date));
        end
    endtask

    // Stimulus in three phases. The first opens with the directed table and has a slow
    // receiver and a mostly busy sender, the second has it the other way round, and the last
    // has no idling at all. The sender waits for every result before each change of phase.
    initial
    begin
        rst_n <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_pct = 11;
        rx_idle_pct = 47;
        for (int k = 0; k < N_CASES; k++)
        begin
            if (DATE_CASES[k].typed)
                deliver_date(DATE_CASES[k].stim, DATE_CASES[k].result);
            else
                deliver_date(DATE_CASES[k].stim, normalise_date(DATE_CASES[k].stim));
        end
        deliver_random_dates();
        await_all_dates();

        tx_idle_pct = 47;
        rx_idle_pct = 11;
        deliver_random_dates();
        await_all_dates();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        deliver_random_dates();
        await_all_dates();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (expected_dates.size() != 0)
        begin
            $error("%0d expected dates never arrived", expected_dates.size());
            failures++;
        end
        if (failures == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // The receiver. After a set number of words it holds off for a long stretch, so the
    // output register fills, the next result backs up behind it and the input stalls.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            dates_taken++;
            if (dates_taken == HOLD_AFTER)
                hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Compare each accepted result word, field by field, with the oldest expected date.
    always @(posedge clk)
    begin
        out_word_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_dates.size() == 0)
            begin
                $error("result %0d-%0d-%0d arrived with no date expected",
                       out_word.norm_year, out_word.norm_month, out_word.norm_day);
                failures++;
            end
            else
            begin
                want = expected_dates.pop_front();
                if (out_word.norm_year !== want.norm_year)
                begin
                    $error("norm_year: expected %0d, got %0d",
                           want.norm_year, out_word.norm_year);
                    failures++;
                end
                if (out_word.norm_month !== want.norm_month)
                begin
                    $error("norm_month: expected %0d, got %0d",
                           want.norm_month, out_word.norm_month);
                    failures++;
                end
                if (out_word.norm_day !== want.norm_day)
                begin
                    $error("norm_day: expected %0d, got %0d",
                           want.norm_day, out_word.norm_day);
                    failures++;
                end
            end
        end
    end

    // Watchdog: several times the slowest legal run, which includes the long hold-off.
    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
